// ===== hw/rtl/u8esc_pkg.sv =====
package u8esc_pkg;

    // job kinds handed from the decoder to the emitter
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_ASCII = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;
    localparam logic [1:0] K_ESC   = 2'd3;

    // output characters
    localparam logic [6:0] CH_BSLASH  = 7'h5C;
    localparam logic [6:0] CH_U_SMALL = 7'h75;
    localparam logic [6:0] CH_U_BIG   = 7'h55;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_A       = 7'h41;

    // index of the last character of a short and a long escape
    localparam logic [3:0] ESC_LAST_SHORT = 4'd5;
    localparam logic [3:0] ESC_LAST_LONG  = 4'd9;

    // default depth of the job queue
    localparam int QDEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] cp;
    } t_job;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] r;
        if (nib <= 4'd9) begin
            r = CH_ZERO + {3'b000, nib};
        end else begin
            r = CH_A + {3'b000, nib} - 7'd10;
        end
        return r;
    endfunction

    // surrogates, overlong three-byte forms and out-of-range four-byte forms
    function automatic logic cp_ok(input logic [20:0] cp, input logic [1:0] len);
        logic ok;
        ok = 1'b1;
        if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
            ok = 1'b0;
        end
        if (len == 2'd2 && cp < 21'h000800) begin
            ok = 1'b0;
        end
        if (len == 2'd3 && (cp < 21'h010000 || cp > 21'h10FFFF)) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== hw/rtl/u8esc_in_if.sv =====
interface u8esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== hw/rtl/u8esc_out_if.sv =====
interface u8esc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       error;
    logic       run_last;

    modport source (output valid, output out_char, output error, output run_last, input ready);
    modport sink   (input valid, input out_char, input error, input run_last, output ready);
endinterface

// ===== hw/rtl/utf8_unicode_escaper.sv =====
// a byte's job goes into the job queue, then its first result into the output register
// throughput: one byte per cycle unless the queue is full; escape runs are 6 or 10 characters
// the emitter moves one character per cycle unless the output stalls, so a run of escapes fills
// the job queue and ready drops until the queue has room again
// reset: synchronous, active low; clears decoder state, queue pointers and output valid
module utf8_unicode_escaper #(
    parameter int P_QDEPTH = u8esc_pkg::QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8esc_in_if.sink    i_in,
    u8esc_out_if.source o_out
);

    // front side: decoder to job queue
    logic            push;
    logic            q_ready;
    u8esc_pkg::t_job front_job;

    // back side: job queue to emitter
    logic            q_valid;
    logic            pop;
    u8esc_pkg::t_job head_job;

    // decoder keeps the partial code point and the count of continuation
    // bytes still due; it turns each byte into at most one job
    u8esc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_byte    (i_in.in_byte),
        .i_eot     (i_in.end_of_text),
        .i_q_ready (q_ready),
        .o_ready   (i_in.ready),
        .o_push    (push),
        .o_job     (front_job)
    );

    // short queue so the decoder keeps taking bytes while an escape drains
    u8esc_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // emitter walks the characters of the head job into the output register;
    // the job leaves the queue with its last character
    u8esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/u8esc_front.sv =====
module u8esc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_eot,
    input  logic              i_q_ready,
    output logic              o_ready,
    output logic              o_push,
    output u8esc_pkg::t_job   o_job
);

    logic [20:0] r_cp,  n_cp;
    logic [1:0]  r_due, n_due;
    logic [1:0]  r_len, n_len;
    logic        acc;
    logic        err;
    logic [20:0] cp_next;

    assign o_ready = i_q_ready;
    assign acc     = i_valid && i_q_ready;
    assign cp_next = {r_cp[14:0], i_byte[5:0]};

    always_comb begin
        n_cp       = r_cp;
        n_due      = r_due;
        n_len      = r_len;
        err        = 1'b0;
        o_job.kind = u8esc_pkg::K_NONE;
        o_job.cp   = {14'd0, i_byte[6:0]};

        if (r_due == 2'd0) begin
            if (i_byte <= 8'h7F) begin
                o_job.kind = u8esc_pkg::K_ASCII;
            end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                n_cp  = {16'd0, i_byte[4:0]};
                n_due = 2'd1;
                n_len = 2'd1;
            end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                n_cp  = {17'd0, i_byte[3:0]};
                n_due = 2'd2;
                n_len = 2'd2;
            end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                n_cp  = {18'd0, i_byte[2:0]};
                n_due = 2'd3;
                n_len = 2'd3;
            end else begin
                err = 1'b1;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            err = 1'b1;
        end else begin
            n_cp  = cp_next;
            n_due = r_due - 2'd1;
            if (n_due == 2'd0) begin
                n_cp  = 21'd0;
                n_len = 2'd0;
                if (u8esc_pkg::cp_ok(cp_next, r_len)) begin
                    o_job.kind = u8esc_pkg::K_ESC;
                    o_job.cp   = cp_next;
                end else begin
                    err = 1'b1;
                end
            end
        end

        // an error or a sequence cut off at the end of text
        if (err || (i_eot && n_due != 2'd0)) begin
            n_cp       = 21'd0;
            n_due      = 2'd0;
            n_len      = 2'd0;
            o_job.kind = u8esc_pkg::K_ERROR;
        end
    end

    assign o_push = acc && (o_job.kind != u8esc_pkg::K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp  <= 21'd0;
            r_due <= 2'd0;
            r_len <= 2'd0;
        end else if (acc) begin
            r_cp  <= n_cp;
            r_due <= n_due;
            r_len <= n_len;
        end
    end

endmodule

// ===== hw/rtl/u8esc_queue.sv =====
module u8esc_queue #(
    parameter int P_DEPTH = u8esc_pkg::QDEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8esc_pkg::t_job   i_job,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output u8esc_pkg::t_job   o_job
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    u8esc_pkg::t_job r_mem [P_DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/u8esc_back.sv =====
module u8esc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  u8esc_pkg::t_job   i_job,
    output logic              o_pop,
    u8esc_out_if.source       o_out
);

    logic [3:0]  r_idx;
    logic        r_ovalid;
    logic [6:0]  r_char;
    logic        r_err;
    logic        r_last;
    logic        adv;
    logic        is_long;
    logic [3:0]  last_idx;
    logic        at_last;
    logic [2:0]  dig;
    logic [2:0]  nib_sel;
    logic [31:0] cp32;
    logic [3:0]  nib;
    logic [6:0]  ch;

    assign adv      = i_valid && (!r_ovalid || o_out.ready);
    assign is_long  = |i_job.cp[20:16];
    assign last_idx = (i_job.kind == u8esc_pkg::K_ESC) ?
                      (is_long ? u8esc_pkg::ESC_LAST_LONG : u8esc_pkg::ESC_LAST_SHORT) : 4'd0;
    assign at_last  = (r_idx == last_idx);
    assign o_pop    = adv && at_last;

    // hex digit position, most significant nibble first
    assign dig     = 3'(r_idx - 4'd2);
    assign nib_sel = is_long ? (3'd7 - dig) : (3'd3 - dig);
    assign cp32    = {11'd0, i_job.cp};
    assign nib     = cp32[{nib_sel, 2'b00} +: 4];

    always_comb begin
        unique case (i_job.kind)
            u8esc_pkg::K_ASCII: ch = i_job.cp[6:0];
            u8esc_pkg::K_ESC: begin
                if (r_idx == 4'd0) begin
                    ch = u8esc_pkg::CH_BSLASH;
                end else if (r_idx == 4'd1) begin
                    ch = is_long ? u8esc_pkg::CH_U_BIG : u8esc_pkg::CH_U_SMALL;
                end else begin
                    ch = u8esc_pkg::hex_char(nib);
                end
            end
            default: ch = 7'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char <= ch;
            r_err  <= (i_job.kind == u8esc_pkg::K_ERROR);
            r_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_idx    <= at_last ? 4'd0 : r_idx + 4'd1;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_char = r_char;
    assign o_out.error    = r_err;
    assign o_out.run_last = r_last;

endmodule

// ===== hw/rtl/u8esc_checker.sv =====
module u8esc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_error,
    input logic       i_out_run_last
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_char) && $stable(i_out_error) && $stable(i_out_run_last)))
        else $error("output changed while stalled");

    // an error result stands alone and carries no character
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_error) |-> (i_out_char == 7'd0 && i_out_run_last))
        else $error("malformed error result");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // reset empties the job queue, so bytes are taken right away
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind utf8_unicode_escaper u8esc_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_error    (o_out.error),
    .i_out_run_last (o_out.run_last)
);

// ===== test/u8esc_checker.sv =====
`timescale 1ns / 100ps

module u8esc_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    u8esc_in_if  i_bytes,
    u8esc_out_if i_chars,
    output int   o_fail_cnt,
    output int   o_pending
);

    typedef struct packed {
        logic [6:0] out_char;
        logic       err;
        logic       run_last;
    } t_out_char;

    t_out_char   due_chars[$];
    logic [20:0] cp_acc;
    logic [1:0]  conts_due;
    logic [1:0]  conts_total;
    int          fail_cnt = 0;

    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? u8esc_pkg::CH_ZERO + {3'b000, nib} :
                               u8esc_pkg::CH_A + {3'b000, nib} - 7'd10;
    endfunction

    // rejects surrogates and values out of range for the sequence length
    function automatic logic scalar_legal(input logic [20:0] cp, input logic [1:0] conts);
        logic surrogate;
        logic overlong;
        logic outside;
        surrogate = (cp >= 21'h00D800) && (cp <= 21'h00DFFF);
        overlong  = (conts == 2'd2) && (cp < 21'h000800);
        outside   = (conts == 2'd3) && ((cp < 21'h010000) || (cp > 21'h10FFFF));
        return !(surrogate || overlong || outside);
    endfunction

    // decodes one byte and queues the characters it produces
    task automatic escape_byte(input logic [7:0] b, input logic eot);
        t_out_char   run[$];
        logic        bad;
        logic [20:0] cp;
        logic [1:0]  conts;
        logic [31:0] cp_wide;
        int          ndig;
        int          k;
        bad = 1'b0;
        if (conts_due == 2'd0) begin
            if (b <= 8'h7F) begin
                run.insert(run.size(), t_out_char'{b[6:0], 1'b0, 1'b0});
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                cp_acc = {16'd0, b[4:0]};
                conts_due = 2'd1;
                conts_total = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                cp_acc = {17'd0, b[3:0]};
                conts_due = 2'd2;
                conts_total = 2'd2;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                cp_acc = {18'd0, b[2:0]};
                conts_due = 2'd3;
                conts_total = 2'd3;
            end else begin
                bad = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            bad = 1'b1;
        end else begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            conts_due = conts_due - 2'd1;
            if (conts_due == 2'd0) begin
                cp = cp_acc;
                conts = conts_total;
                cp_acc = '0;
                conts_total = 2'd0;
                if (scalar_legal(cp, conts)) begin
                    ndig = (cp <= 21'h00FFFF) ? 4 : 8;
                    cp_wide = {11'd0, cp};
                    run.insert(run.size(), t_out_char'{u8esc_pkg::CH_BSLASH, 1'b0, 1'b0});
                    run.insert(run.size(), t_out_char'{
                        (ndig == 4) ? u8esc_pkg::CH_U_SMALL : u8esc_pkg::CH_U_BIG,
                        1'b0, 1'b0});
                    for (k = ndig - 1; k >= 0; k--) begin
                        run.insert(run.size(),
                                   t_out_char'{nibble_char(cp_wide[4*k +: 4]), 1'b0, 1'b0});
                    end
                end else begin
                    bad = 1'b1;
                end
            end
        end
        // one error at most per byte, either malformed or cut short by end of text
        if (bad || (eot && conts_due != 2'd0)) begin
            cp_acc = '0;
            conts_due = 2'd0;
            conts_total = 2'd0;
            run.insert(run.size(), t_out_char'{7'd0, 1'b1, 1'b0});
        end
        if (run.size() > 0) begin
            run[run.size() - 1].run_last = 1'b1;
        end
        foreach (run[i]) begin
            due_chars.insert(due_chars.size(), run[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_char got;
        t_out_char want;
        if (!i_rst_n) begin
            due_chars.delete();
            cp_acc = '0;
            conts_due = 2'd0;
            conts_total = 2'd0;
        end else begin
            if (i_bytes.valid && i_bytes.ready) begin
                escape_byte(i_bytes.in_byte, i_bytes.end_of_text);
            end
            if (i_chars.valid && i_chars.ready) begin
                got = '{i_chars.out_char, i_chars.error, i_chars.run_last};
                if (due_chars.size() == 0) begin
                    fail_cnt++;
                    $error("unexpected item: out_char %h error %b run_last %b",
                           got.out_char, got.err, got.run_last);
                end else begin
                    want = due_chars.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (got.out_char !== want.out_char) begin
                            $error("out_char: expected %h, got %h", want.out_char, got.out_char);
                        end
                        if (got.err !== want.err) begin
                            $error("error: expected %b, got %b", want.err, got.err);
                        end
                        if (got.run_last !== want.run_last) begin
                            $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                        end
                    end
                end
            end
        end
        o_pending = due_chars.size();
        o_fail_cnt = fail_cnt;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int N_DIRECTED     = 25;
    localparam int N_RANDOM       = 125;
    // last stretch of bytes runs with both sides always willing
    localparam int N_TAIL         = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    // extra wait after the final drain, so this covers any straggler
    localparam int END_WAIT       = 20;

    // {end_of_text, byte} for the directed part
    localparam logic [8:0] DIRECTED_ITEMS [N_DIRECTED] = '{
        9'h000, 9'h07F,                 // ascii extremes
        9'h0C2, 9'h080,                 // smallest two-byte value
        9'h0EF, 9'h0BF, 9'h0BF,         // largest short escape
        9'h0ED, 9'h0A0, 9'h080,         // surrogate
        9'h0F0, 9'h090, 9'h080, 9'h080, // smallest long escape
        9'h0F4, 9'h090, 9'h080, 9'h080, // beyond the last code point
        9'h080,                         // stray continuation byte while idle
        9'h0FF,                         // lead byte that never occurs
        9'h0C2, 9'h041,                 // ascii where a continuation is due, dropped
        9'h0E0, 9'h1A0,                 // text ends in the middle of a sequence
        9'h155                          // end of text on a plain ascii byte
    };

    logic       i_clk;
    logic       i_rst_n;
    bit         tail_phase = 1'b0;
    int         sent_cnt   = 0;
    int         quiet_cycles = 0;
    int         fail_cnt;
    int         pending;
    logic [7:0] run_bytes[$];

    u8esc_in_if  in_ch();
    u8esc_out_if out_ch();

    utf8_unicode_escaper DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    u8esc_scoreboard CHK (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bytes    (in_ch),
        .i_chars    (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offers one byte, called at a falling edge; returns at the falling edge after
    // acceptance with valid still high so the next byte can follow back to back
    task automatic push_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (!tail_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // drops valid and holds off until every predicted character has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // sends the queued run; a cut run ends the text right after its last byte,
    // and any byte may end the text now and then
    task automatic send_run(input bit cut);
        foreach (run_bytes[i]) begin
            push_byte(run_bytes[i],
                      (cut && i == run_bytes.size() - 1) || ($urandom_range(0, 24) == 0));
        end
    endtask

    // lead byte for a sequence with n continuation bytes; for n of 2 or 3, half the time
    // one of the leads that sit next to the overlong, surrogate or range boundaries
    function automatic logic [7:0] pick_lead(input int n);
        logic [7:0] b;
        if (n == 1) begin
            b = 8'($urandom_range(8'hC2, 8'hDF));
        end else if (n == 2) begin
            if ($urandom_range(0, 1)) begin
                b = $urandom_range(0, 1) ? 8'hE0 : 8'hED;
            end else begin
                b = 8'($urandom_range(8'hE0, 8'hEF));
            end
        end else begin
            if ($urandom_range(0, 1)) begin
                b = $urandom_range(0, 1) ? 8'hF0 : 8'hF4;
            end else begin
                b = 8'($urandom_range(8'hF0, 8'hF4));
            end
        end
        return b;
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // output side: ready drops in bursts, with longer
    // stretches of steady ready between them
    initial begin
        out_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (tail_phase) begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // watchdog: too long without any item moving on either side means a hang
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int   kind;
        int   n;
        int   run_idx;
        bit   cut;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed bytes, then let everything drain before the random part
        foreach (DIRECTED_ITEMS[i]) begin
            push_byte(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
        end
        drain_results();

        run_idx = 0;
        while (sent_cnt < N_DIRECTED + N_RANDOM) begin
            if (sent_cnt >= N_DIRECTED + N_RANDOM - N_TAIL) begin
                tail_phase = 1'b1;
            end
            // a couple of full pauses in the middle of the random traffic
            if (run_idx == 15 || run_idx == 35) begin
                drain_results();
            end
            run_bytes.delete();
            cut  = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // plain ascii
                run_bytes.insert(run_bytes.size(), 8'($urandom_range(0, 8'h7F)));
            end else if (kind < 75) begin
                // complete two, three or four byte sequence with random payload
                n = (kind < 35) ? 1 : (kind < 55) ? 2 : 3;
                run_bytes.insert(run_bytes.size(), pick_lead(n));
                repeat (n) run_bytes.insert(run_bytes.size(), rand_cont());
            end else if (kind < 85) begin
                // byte that cannot start a sequence
                if ($urandom_range(0, 1)) begin
                    run_bytes.insert(run_bytes.size(), 8'($urandom_range(8'h80, 8'hC1)));
                end else begin
                    run_bytes.insert(run_bytes.size(), 8'($urandom_range(8'hF5, 8'hFF)));
                end
            end else begin
                // sequence broken by a non-continuation byte, or cut by end of text
                n = $urandom_range(1, 3);
                run_bytes.insert(run_bytes.size(), pick_lead(n));
                repeat ($urandom_range(0, n - 1)) run_bytes.insert(run_bytes.size(), rand_cont());
                if (kind < 95) begin
                    if ($urandom_range(0, 1)) begin
                        run_bytes.insert(run_bytes.size(), 8'($urandom_range(0, 8'h7F)));
                    end else begin
                        run_bytes.insert(run_bytes.size(), 8'($urandom_range(8'hC0, 8'hFF)));
                    end
                end else begin
                    cut = 1'b1;
                end
            end
            send_run(cut);
            run_idx++;
        end

        drain_results();
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
